@@ sv/trial_division_prime_test_unit_assert.svh @@
// Assertion macros for the trial division prime test unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TRIAL_DIVISION_PRIME_TEST_UNIT_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TDPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled in reset.
`define TDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ sv/tdpt_pkg.sv @@
// Shared types and constants of the trial division prime test unit.
// No dependencies; used by the input channel interface, the divider, the top level and the testbench.
`default_nettype none

package tdpt_pkg;

  localparam int unsigned NUMBER_W = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

@@ sv/tdpt_in_if.sv @@
// Input channel of the trial division prime test unit: valid/ready plus number.
// Depends on tdpt_pkg.
`default_nettype none

interface tdpt_in_if;
  logic                          valid;
  logic                          ready;
  logic [tdpt_pkg::NUMBER_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

@@ sv/tdpt_out_if.sv @@
// Result channel of the trial division prime test unit: valid/ready plus is_prime.
// No dependencies.
`default_nettype none

interface tdpt_out_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

@@ sv/tdpt_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tdpt_pkg for the status struct.
`default_nettype none

module tdpt_div #(
  parameter int unsigned W = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [W-1:0]   dividend,
  input  wire logic [W-1:0]   divisor,
  output tdpt_pkg::div_sts_t  sts,
  output logic [W-1:0]        quotient,
  output logic [W-1:0]        remainder
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    diff     = shifted - {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = CNT_W'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

@@ sv/trial_division_prime_test_unit.sv @@
// The numbers 0 and 1 are reported not prime without a trial; otherwise the number of trial
// divisors grows to about 2^(NUM_WIDTH/2) for a large prime.
// Each trial is one pass of the shared bit-serial divider, one quotient bit per cycle.
// One item at a time; in_chan.ready is low while busy.
// Reset (synchronous, active low) returns the sequencer to idle and drops any pending result.
// Depends on tdpt_pkg, tdpt_in_if, tdpt_out_if, tdpt_div and the assertion macro header.
`default_nettype none

`include "trial_division_prime_test_unit_assert.svh"

module trial_division_prime_test_unit #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  tdpt_in_if.sink      in_chan,
  tdpt_out_if.source   out_chan
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_FINISH
  } state_t;

  localparam logic [NUM_WIDTH-1:0] FIRST_DIV = NUM_WIDTH'(2);

  state_t                 state_r, state_nxt;
  logic [NUM_WIDTH-1:0]   value_r, value_nxt;
  logic [NUM_WIDTH-1:0]   d_r, d_nxt;
  logic                   prime_r, prime_nxt;
  logic                   start_r, start_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_prime_r, out_prime_nxt;
  logic [NUM_WIDTH-1:0]   in_val;
  logic [NUM_WIDTH-1:0]   quo;
  logic [NUM_WIDTH-1:0]   rem;
  tdpt_pkg::div_sts_t     div_sts;

  tdpt_div #(
    .W (NUM_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (value_r),
    .divisor   (d_r),
    .sts       (div_sts),
    .quotient  (quo),
    .remainder (rem)
  );

  assign in_val = NUM_WIDTH'(in_chan.number);

  always_comb begin
    state_nxt     = state_r;
    value_nxt     = value_r;
    d_nxt         = d_r;
    prime_nxt     = prime_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          value_nxt = in_val;
          d_nxt     = FIRST_DIV;
          if (in_val < FIRST_DIV) begin
            prime_nxt = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            start_nxt = 1'b1;
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (div_sts.done) begin
          if (d_r > quo) begin
            prime_nxt = 1'b1;
            state_nxt = ST_FINISH;
          end else if (rem == '0) begin
            prime_nxt = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            d_nxt     = d_r + NUM_WIDTH'(1);
            start_nxt = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = prime_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r     <= value_nxt;
    d_r         <= d_nxt;
    prime_r     <= prime_nxt;
    out_prime_r <= out_prime_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_chan.ready     = (state_r == ST_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.is_prime = out_prime_r;

  `TDPT_ASSERT_SAME(a_idle_div_quiet, clk, rst_n, state_r == ST_IDLE, !div_sts.busy && !start_r)
  `TDPT_ASSERT_SAME(a_done_in_wait, clk, rst_n, div_sts.done, state_r == ST_WAIT)
  `TDPT_ASSERT_SAME(a_divisor_floor, clk, rst_n, state_r == ST_WAIT, d_r >= FIRST_DIV)
  `TDPT_ASSERT_NEXT(a_start_busy, clk, rst_n, start_r, div_sts.busy)

endmodule

`default_nettype wire

@@ tb/trial_division_prime_test_unit_tb.sv @@
// Self-checking testbench for the trial division prime test unit: directed and random
// numbers, with a primality predictor and a result checker. Depends on tdpt_pkg,
// tdpt_in_if, tdpt_out_if and trial_division_prime_test_unit.
`default_nettype none

module trial_division_prime_test_unit_tb;

  localparam int unsigned NUM_WIDTH   = 32;
  localparam longint unsigned NUM_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - NUM_WIDTH);
  localparam int unsigned HOLD_CYCLES = 2000;
  localparam int unsigned IDLE_PCT    = 19;

  typedef struct packed {
    logic [tdpt_pkg::NUMBER_W-1:0] number;
    logic                          is_prime;
  } prime_verdict_t;

  logic clk;
  logic rst_n;
  logic no_idle = 1'b0;
  logic hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  prime_verdict_t expected_verdicts[$];

  tdpt_in_if  in_ch ();
  tdpt_out_if out_ch ();

  trial_division_prime_test_unit #(.NUM_WIDTH(NUM_WIDTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic primality(input logic [tdpt_pkg::NUMBER_W-1:0] n);
    longint unsigned v;
    longint unsigned d;
    v = longint'(n) & NUM_MASK;
    if (v < 2) return 1'b0;
    for (d = 2; d <= v / d; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // keep most numbers narrow; wide ones get a small factor so the search ends early
  function automatic logic [tdpt_pkg::NUMBER_W-1:0] rand_number();
    int unsigned pick;
    int unsigned w;
    int unsigned f;
    logic [tdpt_pkg::NUMBER_W-1:0] v;
    pick = $urandom_range(99);
    if (pick < 70) begin
      w = $urandom_range(16, 1);
      v = $urandom & ((32'h1 << w) - 1);
    end else if (pick < 80) begin
      w = $urandom_range(20, 17);
      v = $urandom & ((32'h1 << w) - 1);
    end else begin
      f = $urandom_range(64, 2);
      v = $urandom;
      v = v - (v % f);
    end
    return v;
  endfunction

  task automatic send_number(input logic [tdpt_pkg::NUMBER_W-1:0] n);
    prime_verdict_t entry;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.number <= n;
    do @(posedge clk); while (!in_ch.ready);
    entry.number   = n;
    entry.is_prime = primality(n);
    expected_verdicts.push_back(entry);
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  always @(posedge clk) begin
    prime_verdict_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result item with no number pending, is_prime=%0b",
                     $time, out_ch.is_prime);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_ch.is_prime !== want.is_prime) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: is_prime for %0d: expected %0b, got %0b",
                       $time, want.number, want.is_prime, out_ch.is_prime);
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic test_zero_to_three();
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'd2);
    send_number(32'd3);
    send_number(32'd4);
  endtask

  // squares of primes land exactly on the loop bound
  task automatic test_prime_squares();
    send_number(32'd9);
    send_number(32'd25);
    send_number(32'd49);
    send_number(32'd121);
    send_number(32'd63001);
    send_number(32'd1042441);
  endtask

  task automatic test_primes();
    send_number(32'd5);
    send_number(32'd997);
    send_number(32'd65521);
    send_number(32'd65537);
    send_number(32'd1000003);
    send_number(32'd4194301);
  endtask

  task automatic test_wide_numbers();
    send_number(32'hFFFF_FFFF);
    send_number(32'hFFFF_FFFE);
    send_number(32'h8000_0000);
    send_number(32'h5555_5555);
    send_number(32'hAAAA_AAAA);
    send_number(32'd65535);
  endtask

  task automatic test_back_to_back();
    no_idle <= 1'b1;
    repeat (30) send_number(rand_number());
    no_idle <= 1'b0;
  endtask

  task automatic test_backpressure();
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    no_idle <= 1'b1;
    repeat (8) send_number($urandom_range(255));
    no_idle <= 1'b0;
  endtask

  task automatic test_random_numbers();
    repeat (50) send_number(rand_number());
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.number <= '0;
    rst_n        <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_to_three();
    test_prime_squares();
    test_primes();
    test_wide_numbers();
    test_back_to_back();
    test_backpressure();
    test_random_numbers();
    in_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
